// ===== sv/mts_pkg.sv =====
// shared constants and types for the markup tag stripper
`default_nettype none

package mts_pkg;

	localparam int unsigned DEPTH_BITS = 8;

	localparam logic [7:0] CH_OPEN   = 8'h3C;
	localparam logic [7:0] CH_CLOSE  = 8'h3E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef logic [DEPTH_BITS-1:0] depth_t;

	localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};

	// one step request from the stage register to the tracker
	typedef struct packed {
		logic advance;
		logic last;
	} step_t;

endpackage

`default_nettype wire

// ===== sv/mts_in_if.sv =====
// input channel: raw text bytes with an end-of-text flag
`default_nettype none

interface mts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink (input valid, input in_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/mts_out_if.sv =====
// output channel: kept bytes and end-of-text markers
`default_nettype none

interface mts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_text;

	modport source (output valid, output out_byte, output has_byte, output end_of_text,
		input ready);
	modport sink (input valid, input out_byte, input has_byte, input end_of_text,
		output ready);
endinterface

`default_nettype wire

// ===== sv/markup_tag_stripper_top.sv =====
// Markup tag stripper top level: drops bytes inside angle-bracket markup.
// Channel text (sink) takes one raw byte per transfer with a last flag.
// Channel stripped (source) gives one result per kept byte, and one empty
// result (has_byte 0, end_of_text 1) when the final byte of a text is dropped.
// Dropped bytes that are not final give no result.
// A transfer on text lands in a stage register; when that byte advances it
// updates the markup state and, if it produces a result, loads the result
// register, which offers the result on stripped.
// Throughput is one byte per cycle while stripped does not stall; text.ready
// stays high while the result register is free or being emptied in the same
// cycle.
// When stripped stalls, the held result blocks only a byte that needs to
// produce a result; dropped bytes keep flowing through.
// Reset (arst_n low) clears the stage and result valids and the markup,
// quote and backslash state. The final byte of each text also returns the
// state to its reset value for the next text.
`default_nettype none

module markup_tag_stripper_top
	import mts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mts_in_if.sink    text,
	mts_out_if.source stripped
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_byte_q;
	logic       end_q;

	logic  keep;
	logic  produce;
	logic  out_free;
	logic  advance;
	step_t step;

	assign produce  = valid_s1 && (keep || last_s1);
	assign out_free = !out_valid_q || stripped.ready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign text.ready = !valid_s1 || advance;

	assign step.advance = advance;
	assign step.last    = last_s1;

	mts_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.keep    (keep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_byte_q <= keep ? byte_s1 : 8'h00;
			has_byte_q <= keep;
			end_q      <= last_s1;
		end
	end

	assign stripped.valid       = out_valid_q;
	assign stripped.out_byte    = out_byte_q;
	assign stripped.has_byte    = has_byte_q;
	assign stripped.end_of_text = end_q;

`ifndef SYNTHESIS
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		stripped.valid |-> (stripped.has_byte || stripped.end_of_text))
		else $error("empty result without end of text");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stripped.valid && !stripped.has_byte |-> stripped.out_byte == 8'h00)
		else $error("empty result carries a byte");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> text.ready)
		else $error("stage empty but input not ready");
	a_drop_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !keep && !last_s1 |-> advance)
		else $error("dropped byte stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/mts_tracker.sv =====
// markup depth, quote and backslash state with the per-byte keep decision
`default_nettype none

module mts_tracker
	import mts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire step_t      step,
	input  wire logic [7:0] in_byte,
	output logic            keep
);

	depth_t depth_q;
	logic   quote_q;
	logic   odd_q;

	depth_t depth_up;
	depth_t depth_n;
	logic   quote_n;
	logic   odd_n;

	always_comb begin
		depth_up = depth_q;
		if (!quote_q && in_byte == CH_OPEN && depth_q != DEPTH_MAX) begin
			depth_up = depth_q + depth_t'(1);
		end
		quote_n = quote_q;
		if (in_byte == CH_QUOTE && !odd_q) begin
			quote_n = ~quote_q;
		end
		keep = (depth_up == '0);
		depth_n = depth_up;
		if (depth_up != '0 && !quote_n && in_byte == CH_CLOSE) begin
			depth_n = depth_up - depth_t'(1);
		end
		odd_n = (in_byte == CH_BSLASH) ? ~odd_q : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			quote_q <= 1'b0;
			odd_q   <= 1'b0;
		end else if (step.advance) begin
			if (step.last) begin
				depth_q <= '0;
				quote_q <= 1'b0;
				odd_q   <= 1'b0;
			end else begin
				depth_q <= depth_n;
				quote_q <= quote_n;
				odd_q   <= odd_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && step.last |=> (depth_q == '0 && !quote_q && !odd_q))
		else $error("state not cleared after end of text");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step.advance |=> $stable({depth_q, quote_q, odd_q}))
		else $error("state changed without a step");
	a_depth_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		step.advance && !step.last && !quote_q && in_byte == CH_OPEN &&
		depth_q == DEPTH_MAX |=> depth_q == DEPTH_MAX)
		else $error("markup depth wrapped");
`endif

endmodule

`default_nettype wire
